/* sv/hsup_pkg.sv */
// ----------------------------------------------------------------------------
// hsup_pkg
// Shared types and codes for the heater supervisor: modes, faults, operation
// and register codes, the configuration bundle, the PID result bundle and the status bundle.
// ----------------------------------------------------------------------------
package hsup_pkg;

  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned DUTY_W  = 15;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned INTEG_W = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_OFF       = 2'd0,
    MODE_HEATING   = 2'd1,
    MODE_REGULATED = 2'd2,
    MODE_SHUTDOWN  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FAULT_NONE       = 2'd0,
    FAULT_OVERHEAT   = 2'd1,
    FAULT_AMBIENT    = 2'd2,
    FAULT_REGULATION = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ON   = 2'd1,
    OP_OFF  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET     = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_OVERHEAT   = 3'd4,
    REG_AMBIENT    = 3'd5,
    REG_AMBIENT_TO = 3'd6,
    REG_REGUL_TO   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target;
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        ki;
    logic [GAIN_W-1:0]        kd;
    logic signed [TEMP_W-1:0] overheat;
    logic signed [TEMP_W-1:0] ambient;
    logic [TICK_W-1:0]        ambient_to;
    logic [TICK_W-1:0]        regul_to;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic [DUTY_W-1:0]         duty;
  } pid_res_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    mode_e             mode;
    fault_e            fault;
    logic              led;
  } result_t;

endpackage

/* sv/hsup_if.sv */
// ----------------------------------------------------------------------------
// hsup_in_if / hsup_out_if
// Valid/ready channels for event beats in and status beats out.
// ----------------------------------------------------------------------------
interface hsup_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic signed [hsup_pkg::TEMP_W-1:0] sample_temperature;
  logic        sample_valid;

  modport source (output valid, op, sample_temperature, sample_valid, input ready);
  modport sink   (input valid, op, sample_temperature, sample_valid, output ready);
endinterface

interface hsup_out_if;
  logic        valid;
  logic        ready;
  logic [hsup_pkg::DUTY_W-1:0] duty_level;
  logic [1:0]  heater_mode;
  logic [1:0]  fault_code;
  logic        indicator_led;

  modport source (output valid, duty_level, heater_mode, fault_code, indicator_led,
                  input ready);
  modport sink   (input valid, duty_level, heater_mode, fault_code, indicator_led,
                  output ready);
endinterface

/* sv/hsup_cfg.sv */
// ----------------------------------------------------------------------------
// hsup_cfg
// Configuration register file: setpoint, gains, limits and timeouts.
// ----------------------------------------------------------------------------
module hsup_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hsup_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hsup_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output hsup_pkg::cfg_t                      cfg_o
);

  hsup_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (hsup_pkg::cfg_idx_e'(cfg_idx_i))
        hsup_pkg::REG_TARGET:     cfg_d.target     = $signed(cfg_data_i);
        hsup_pkg::REG_GAIN_P:     cfg_d.kp         = cfg_data_i;
        hsup_pkg::REG_GAIN_I:     cfg_d.ki         = cfg_data_i;
        hsup_pkg::REG_GAIN_D:     cfg_d.kd         = cfg_data_i;
        hsup_pkg::REG_OVERHEAT:   cfg_d.overheat   = $signed(cfg_data_i);
        hsup_pkg::REG_AMBIENT:    cfg_d.ambient    = $signed(cfg_data_i);
        hsup_pkg::REG_AMBIENT_TO: cfg_d.ambient_to = cfg_data_i;
        hsup_pkg::REG_REGUL_TO:   cfg_d.regul_to   = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target     <= 16'sd1600;
      cfg_q.kp         <= 16'd256;
      cfg_q.ki         <= 16'd0;
      cfg_q.kd         <= 16'd0;
      cfg_q.overheat   <= 16'sd4800;
      cfg_q.ambient    <= 16'sd640;
      cfg_q.ambient_to <= 16'd300;
      cfg_q.regul_to   <= 16'd3000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/hsup_pid.sv */
// ----------------------------------------------------------------------------
// hsup_pid
// Q8.8 PID step: error, conditional saturating integral, three products,
// sum and clamp to the duty range.
// ----------------------------------------------------------------------------
module hsup_pid #(
  parameter int DUTY_MAX           = 25600,
  parameter int DUTY_MIN           = 0,
  parameter int INTEGRATE_DEADBAND = 16,
  parameter int WINDUP_MARGIN      = 1
) (
  input  hsup_pkg::cfg_t                                 cfg_i,
  input  logic signed [hsup_pkg::TEMP_W-1:0]             temp_i,
  input  logic signed [hsup_pkg::INTEG_W-1:0]            integ_i,
  input  logic signed [hsup_pkg::ERR_W-1:0]              prev_err_i,
  input  logic [hsup_pkg::DUTY_W-1:0]                    last_duty_i,
  output hsup_pkg::pid_res_t                             res_o
);

  localparam int unsigned ERR_W   = hsup_pkg::ERR_W;
  localparam int unsigned INTEG_W = hsup_pkg::INTEG_W;
  localparam int unsigned DUTY_W  = hsup_pkg::DUTY_W;
  localparam int unsigned P_W     = ERR_W + 17;
  localparam int unsigned I_W     = INTEG_W + 17;
  localparam int unsigned D_W     = ERR_W + 18;
  localparam int unsigned SUM_W   = I_W + 2;

  localparam logic signed [ERR_W-1:0] DEADBAND   = ERR_W'(INTEGRATE_DEADBAND);
  localparam logic [DUTY_W-1:0]       WINDUP_LVL = DUTY_W'(DUTY_MAX - WINDUP_MARGIN);
  localparam logic signed [SUM_W-1:0] SUM_HI     = SUM_W'((DUTY_MAX + 1) * 256);
  localparam logic signed [SUM_W-1:0] SUM_LO     = SUM_W'(DUTY_MIN * 256);

  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W:0]     deriv;
  logic signed [INTEG_W:0]   integ_ext;
  logic signed [INTEG_W-1:0] integ_new;
  logic                      integrate;
  logic signed [P_W-1:0]     p_term;
  logic signed [I_W-1:0]     i_term;
  logic signed [D_W-1:0]     d_term;
  logic signed [SUM_W-1:0]   sum;
  logic [DUTY_W-1:0]         duty;

  assign err   = $signed({cfg_i.target[15], cfg_i.target}) - $signed({temp_i[15], temp_i});
  assign deriv = $signed({err[ERR_W-1], err}) - $signed({prev_err_i[ERR_W-1], prev_err_i});

  // integrate outside the deadband, or when pinned at the top to pull back
  assign integrate = (err > DEADBAND) || (err < -DEADBAND) || (last_duty_i >= WINDUP_LVL);

  assign integ_ext = $signed({integ_i[INTEG_W-1], integ_i})
                   + $signed({{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err});

  always_comb begin
    integ_new = integ_i;
    if (integrate) begin
      if (integ_ext[INTEG_W] != integ_ext[INTEG_W-1]) begin
        integ_new = integ_ext[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
        integ_new = integ_ext[INTEG_W-1:0];
      end
    end
  end

  assign p_term = $signed({1'b0, cfg_i.kp}) * err;
  assign i_term = $signed({1'b0, cfg_i.ki}) * integ_new;
  assign d_term = $signed({1'b0, cfg_i.kd}) * deriv;

  assign sum = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);

  always_comb begin
    if (sum >= SUM_HI) begin
      duty = DUTY_W'(DUTY_MAX);
    end else if (sum < SUM_LO) begin
      duty = DUTY_W'(DUTY_MIN);
    end else begin
      duty = sum[DUTY_W+7:8];
    end
  end

  assign res_o.err   = err;
  assign res_o.integ = integ_new;
  assign res_o.duty  = duty;

endmodule

/* sv/hsup_ctrl.sv */
// ----------------------------------------------------------------------------
// hsup_ctrl
// Supervisor state: mode, fault, PID history, heating timer, settle countdown
// and LED. Applies one event per enabled cycle and reports the new status.
// ----------------------------------------------------------------------------
module hsup_ctrl #(
  parameter int DUTY_MAX           = 25600,
  parameter int DUTY_MIN           = 0,
  parameter int SETTLE_TICKS       = 10,
  parameter int INTEGRATE_DEADBAND = 16,
  parameter int WINDUP_MARGIN      = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  logic [1:0]                           op_i,
  input  logic signed [hsup_pkg::TEMP_W-1:0]   temp_i,
  input  logic                                 sample_valid_i,
  input  hsup_pkg::cfg_t                       cfg_i,
  output hsup_pkg::result_t                    res_o
);

  localparam int unsigned CNT_W  = hsup_pkg::CNT_W;
  localparam int unsigned TICK_W = hsup_pkg::TICK_W;

  hsup_pkg::mode_e                         mode_q, mode_d;
  hsup_pkg::fault_e                        fault_q, fault_d;
  logic signed [hsup_pkg::INTEG_W-1:0]     integ_q, integ_d;
  logic signed [hsup_pkg::ERR_W-1:0]       prev_err_q, prev_err_d;
  logic [hsup_pkg::DUTY_W-1:0]             last_duty_q, last_duty_d;
  logic [TICK_W-1:0]                       ticks_q, ticks_d;
  logic [CNT_W-1:0]                        settle_q, settle_d;
  logic                                    led_q, led_d;

  hsup_pkg::pid_res_t pid;
  logic               active;
  logic [TICK_W-1:0]  ticks_inc;

  hsup_pid #(
    .DUTY_MAX           (DUTY_MAX),
    .DUTY_MIN           (DUTY_MIN),
    .INTEGRATE_DEADBAND (INTEGRATE_DEADBAND),
    .WINDUP_MARGIN      (WINDUP_MARGIN)
  ) u_pid (
    .cfg_i       (cfg_i),
    .temp_i      (temp_i),
    .integ_i     (integ_q),
    .prev_err_i  (prev_err_q),
    .last_duty_i (last_duty_q),
    .res_o       (pid)
  );

  assign active    = (mode_q == hsup_pkg::MODE_HEATING) || (mode_q == hsup_pkg::MODE_REGULATED);
  assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;

  always_comb begin
    mode_d      = mode_q;
    fault_d     = fault_q;
    integ_d     = integ_q;
    prev_err_d  = prev_err_q;
    last_duty_d = last_duty_q;
    ticks_d     = ticks_q;
    settle_d    = settle_q;
    led_d       = led_q;
    case (op_i)
      hsup_pkg::OP_TICK: begin
        if (active && sample_valid_i) begin
          if (temp_i > cfg_i.overheat) begin
            mode_d      = hsup_pkg::MODE_SHUTDOWN;
            fault_d     = hsup_pkg::FAULT_OVERHEAT;
            led_d       = 1'b0;
            last_duty_d = '0;
          end else begin
            integ_d     = pid.integ;
            prev_err_d  = pid.err;
            last_duty_d = pid.duty;
            if (mode_q == hsup_pkg::MODE_HEATING) begin
              ticks_d = ticks_inc;
            end
            if (mode_q == hsup_pkg::MODE_HEATING && temp_i < cfg_i.ambient
                && ticks_inc > cfg_i.ambient_to) begin
              mode_d      = hsup_pkg::MODE_SHUTDOWN;
              fault_d     = hsup_pkg::FAULT_AMBIENT;
              led_d       = 1'b0;
              last_duty_d = '0;
            end else if (mode_q == hsup_pkg::MODE_HEATING && temp_i < cfg_i.target
                         && ticks_inc > cfg_i.regul_to) begin
              mode_d      = hsup_pkg::MODE_SHUTDOWN;
              fault_d     = hsup_pkg::FAULT_REGULATION;
              led_d       = 1'b0;
              last_duty_d = '0;
            end else begin
              // run the settle countdown, then blink or hold the LED
              if (settle_q != '0) begin
                settle_d = settle_q - 1'b1;
                if (settle_q == CNT_W'(1)) begin
                  mode_d = hsup_pkg::MODE_REGULATED;
                end
              end
              led_d = (mode_d == hsup_pkg::MODE_REGULATED) ? 1'b1 : ~led_q;
            end
          end
        end
      end
      hsup_pkg::OP_ON: begin
        if (!active) begin
          integ_d     = '0;
          prev_err_d  = '0;
          last_duty_d = '0;
          ticks_d     = '0;
          settle_d    = CNT_W'(SETTLE_TICKS);
          fault_d     = hsup_pkg::FAULT_NONE;
          mode_d      = hsup_pkg::MODE_HEATING;
        end
      end
      hsup_pkg::OP_OFF: begin
        mode_d      = hsup_pkg::MODE_OFF;
        fault_d     = hsup_pkg::FAULT_NONE;
        led_d       = 1'b0;
        last_duty_d = '0;
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= hsup_pkg::MODE_OFF;
      fault_q     <= hsup_pkg::FAULT_NONE;
      integ_q     <= '0;
      prev_err_q  <= '0;
      last_duty_q <= '0;
      ticks_q     <= '0;
      settle_q    <= '0;
      led_q       <= 1'b0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      fault_q     <= fault_d;
      integ_q     <= integ_d;
      prev_err_q  <= prev_err_d;
      last_duty_q <= last_duty_d;
      ticks_q     <= ticks_d;
      settle_q    <= settle_d;
      led_q       <= led_d;
    end
  end

  always_comb begin
    res_o.mode  = mode_d;
    res_o.fault = fault_d;
    res_o.led   = led_d;
    res_o.duty  = ((mode_d == hsup_pkg::MODE_HEATING) || (mode_d == hsup_pkg::MODE_REGULATED))
                  ? last_duty_d : '0;
  end

endmodule

/* sv/heater_supervisor_with_pid_top.sv */
// Flow: a taken event beat is held in the input register; the PID and supervisor
// update is combinational from there into the result register. Throughput: one
// event per cycle unless the status receiver stalls.
// Reset: mode off, no fault, PID history, timers and LED cleared; configuration
// registers load their default setpoint, gains, limits and timeouts.
// ----------------------------------------------------------------------------
// heater_supervisor_with_pid_top
// Heater supervisor with fixed-point PID: input register, supervisor step,
// result register, plus the configuration register file.
// ----------------------------------------------------------------------------
module heater_supervisor_with_pid_top #(
  parameter int DUTY_MAX           = 25600,
  parameter int DUTY_MIN           = 0,
  parameter int SETTLE_TICKS       = 10,
  parameter int INTEGRATE_DEADBAND = 16,
  parameter int WINDUP_MARGIN      = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hsup_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hsup_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  hsup_in_if.sink                          in_if,
  hsup_out_if.source                       out_if
);

  hsup_pkg::cfg_t    cfg;
  hsup_pkg::result_t res;

  logic                                s1_valid_q, s1_valid_d;
  logic [1:0]                          op_q;
  logic signed [hsup_pkg::TEMP_W-1:0]  temp_q;
  logic                                svalid_q;
  logic                                out_valid_q, out_valid_d;
  hsup_pkg::result_t                   out_q;
  logic                                advance;
  logic                                in_take;

  hsup_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hsup_ctrl #(
    .DUTY_MAX           (DUTY_MAX),
    .DUTY_MIN           (DUTY_MIN),
    .SETTLE_TICKS       (SETTLE_TICKS),
    .INTEGRATE_DEADBAND (INTEGRATE_DEADBAND),
    .WINDUP_MARGIN      (WINDUP_MARGIN)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .op_i           (op_q),
    .temp_i         (temp_q),
    .sample_valid_i (svalid_q),
    .cfg_i          (cfg),
    .res_o          (res)
  );

  // advance the held beat whenever the result slot is free or draining
  assign advance     = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || advance;
  assign in_take     = in_if.valid && in_if.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q     <= in_if.op;
      temp_q   <= in_if.sample_temperature;
      svalid_q <= in_if.sample_valid;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.duty_level    = out_q.duty;
  assign out_if.heater_mode   = out_q.mode;
  assign out_if.fault_code    = out_q.fault;
  assign out_if.indicator_led = out_q.led;

endmodule

/* dv/tb_heater_supervisor_with_pid_top.sv */
// ----------------------------------------------------------------------------
// tb_heater_supervisor_with_pid_top
// Self-checking bench for the heater supervisor. Event beats come from a
// queue filled by a stimulus sequence: a directed pass through the mode
// corners, then heating sessions with random temperatures and noise beats,
// under several register settings and handshake idle profiles. Each taken
// event runs through a cycle-free model of the supervisor and PID; status
// beats are checked in order against its outputs.
// ----------------------------------------------------------------------------
module tb_heater_supervisor_with_pid_top;
  import hsup_pkg::*;

  localparam int CLK_PERIOD         = 8;
  localparam int RESET_CYCLES       = 6;
  localparam int RUN_LIMIT          = 2000000;
  localparam int HOLD_CYCLES        = 300;
  localparam int DRAIN_CYCLES       = 8;
  localparam int MAX_REPORTS        = 10;
  localparam int DUTY_MAX           = 25600;
  localparam int DUTY_MIN           = 0;
  localparam int SETTLE_TICKS       = 10;
  localparam int INTEGRATE_DEADBAND = 16;
  localparam int WINDUP_MARGIN      = 1;
  localparam longint INTEG_HI       = 64'sd2147483647;
  localparam longint INTEG_LO       = -64'sd2147483648;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct {
    logic [1:0]               op;
    logic signed [TEMP_W-1:0] temp;
    logic                     sample_ok;
  } heat_event_t;

  typedef enum int {
    CFG_SHORT_TIMEOUTS, CFG_ALL_HIGH, CFG_ALL_LOW, CFG_FULL_RANDOM, CFG_NEAR_TARGET
  } cfg_profile_e;

  typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_profile_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  hsup_in_if  ev_ch ();
  hsup_out_if st_ch ();

  heater_supervisor_with_pid_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (ev_ch),
    .out_if     (st_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Supervisor model state and its register copy
  cfg_t                      cfg_m;
  mode_e                     mode_m;
  fault_e                    fault_m;
  logic signed [INTEG_W-1:0] integ_m;
  logic signed [ERR_W-1:0]   prev_err_m;
  logic [DUTY_W-1:0]         duty_m;
  logic [TICK_W-1:0]         heat_ticks_m;
  logic [CNT_W-1:0]          settle_m;
  logic                      led_m;

  heat_event_t event_q[$];
  result_t     status_q[$];
  int          items_queued    = 0;
  int          results_checked = 0;
  int          mismatches      = 0;
  int          send_idle_pct   = 0;
  int          stall_pct       = 0;
  bit          hold_go         = 1'b0;
  bit          sink_hold       = 1'b0;
  logic        ev_taken;

  function automatic void shut_heater(mode_e m, fault_e f);
    mode_m  = m;
    fault_m = f;
    led_m   = 1'b0;
    duty_m  = '0;
  endfunction

  function automatic void run_pid(int temp);
    longint err, mag, acc, deriv, sum;
    err = longint'($signed(cfg_m.target)) - longint'(temp);
    mag = (err < 0) ? -err : err;
    // integrate outside the deadband, or while pinned at full duty
    if (mag > INTEGRATE_DEADBAND || longint'(duty_m) >= DUTY_MAX - WINDUP_MARGIN) begin
      acc = longint'(integ_m) + err;
      if (acc > INTEG_HI) acc = INTEG_HI;
      if (acc < INTEG_LO) acc = INTEG_LO;
      integ_m = acc[INTEG_W-1:0];
    end
    deriv = err - longint'(prev_err_m);
    sum = longint'(cfg_m.kp) * err + longint'(cfg_m.ki) * longint'(integ_m)
        + longint'(cfg_m.kd) * deriv;
    if (sum >= longint'(DUTY_MAX + 1) * 256) duty_m = DUTY_W'(DUTY_MAX);
    else if (sum < longint'(DUTY_MIN) * 256) duty_m = DUTY_W'(DUTY_MIN);
    else duty_m = DUTY_W'(sum >>> 8);
    prev_err_m = ERR_W'(err);
  endfunction

  function automatic void tick_heater(int temp, logic ok);
    int tgt, ovh, amb;
    tgt = int'(cfg_m.target);
    ovh = int'(cfg_m.overheat);
    amb = int'(cfg_m.ambient);
    if (mode_m == MODE_OFF || mode_m == MODE_SHUTDOWN || !ok) return;
    if (temp > ovh) begin
      shut_heater(MODE_SHUTDOWN, FAULT_OVERHEAT);
      return;
    end
    run_pid(temp);
    if (mode_m == MODE_HEATING) begin
      if (heat_ticks_m != '1) heat_ticks_m = heat_ticks_m + 1'b1;
      if (temp < amb && heat_ticks_m > cfg_m.ambient_to) begin
        shut_heater(MODE_SHUTDOWN, FAULT_AMBIENT);
        return;
      end
      if (temp < tgt && heat_ticks_m > cfg_m.regul_to) begin
        shut_heater(MODE_SHUTDOWN, FAULT_REGULATION);
        return;
      end
    end
    if (settle_m != '0) begin
      settle_m = settle_m - 1'b1;
      if (settle_m == '0) mode_m = MODE_REGULATED;
    end
    if (mode_m == MODE_REGULATED) led_m = 1'b1;
    else led_m = ~led_m;
  endfunction

  function automatic void turn_on();
    if (mode_m == MODE_HEATING || mode_m == MODE_REGULATED) return;
    integ_m      = '0;
    prev_err_m   = '0;
    duty_m       = '0;
    heat_ticks_m = '0;
    settle_m     = CNT_W'(SETTLE_TICKS);
    fault_m      = FAULT_NONE;
    mode_m       = MODE_HEATING;
  endfunction

  function automatic result_t supervise_event(heat_event_t ev);
    result_t r;
    case (ev.op)
      OP_TICK: tick_heater(int'(ev.temp), ev.sample_ok);
      OP_ON:   turn_on();
      OP_OFF:  shut_heater(MODE_OFF, FAULT_NONE);
      default: ;
    endcase
    r.duty  = (mode_m == MODE_HEATING || mode_m == MODE_REGULATED) ? duty_m : '0;
    r.mode  = mode_m;
    r.fault = fault_m;
    r.led   = led_m;
    return r;
  endfunction

  // Event driver: hold a beat until taken, then advance or idle
  always @(negedge clk_i) begin
    heat_event_t nxt;
    if (rst_ni && (!ev_ch.valid || ev_taken)) begin
      if (event_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = event_q.pop_front();
        ev_ch.valid              <= 1'b1;
        ev_ch.op                 <= nxt.op;
        ev_ch.sample_temperature <= nxt.temp;
        ev_ch.sample_valid       <= nxt.sample_ok;
      end else begin
        ev_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    st_ch.ready <= !sink_hold && ($urandom_range(99) >= stall_pct);
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  // Status checker and event predictor
  always @(posedge clk_i) begin
    heat_event_t ev;
    result_t     want;
    if (!rst_ni) begin
      ev_taken <= 1'b0;
    end else begin
      if (st_ch.valid && st_ch.ready) begin
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected status beat: duty %0d mode %0d fault %0d led %0b",
                     st_ch.duty_level, st_ch.heater_mode, st_ch.fault_code,
                     st_ch.indicator_led);
        end else begin
          want = status_q.pop_front();
          results_checked++;
          if (st_ch.duty_level !== want.duty || st_ch.heater_mode !== want.mode ||
              st_ch.fault_code !== want.fault || st_ch.indicator_led !== want.led) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"status beat %0d mismatch (expected/actual): duty %0d/%0d ",
                        "mode %0d/%0d fault %0d/%0d led %0b/%0b"},
                       results_checked, want.duty, st_ch.duty_level,
                       want.mode, st_ch.heater_mode, want.fault, st_ch.fault_code,
                       want.led, st_ch.indicator_led);
          end
        end
      end
      if (ev_ch.valid && ev_ch.ready) begin
        ev.op        = ev_ch.op;
        ev.temp      = ev_ch.sample_temperature;
        ev.sample_ok = ev_ch.sample_valid;
        status_q.push_back(supervise_event(ev));
      end
      ev_taken <= ev_ch.valid && ev_ch.ready;
    end
  end

  task automatic queue_event(logic [1:0] op, int temp, logic ok);
    heat_event_t ev;
    if (temp > 32767) temp = 32767;
    if (temp < -32768) temp = -32768;
    ev.op        = op;
    ev.temp      = temp[TEMP_W-1:0];
    ev.sample_ok = ok;
    event_q.push_back(ev);
    items_queued++;
  endtask

  function automatic int rand_temp();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // Turn on, run a string of mostly valid ticks around the setpoint
  task automatic queue_session();
    int tgt, spread, len, pick;
    tgt = int'(cfg_m.target);
    case ($urandom_range(3))
      0:       spread = 8;
      1:       spread = 64;
      2:       spread = 1024;
      default: spread = 32768;
    endcase
    queue_event(OP_ON, rand_temp(), 1'($urandom_range(1)));
    len = $urandom_range(24, 4);
    repeat (len) begin
      pick = $urandom_range(99);
      if (pick < 84)
        queue_event(OP_TICK, tgt + int'($urandom_range(2 * spread)) - spread, 1'b1);
      else if (pick < 90) queue_event(OP_TICK, rand_temp(), 1'b0);
      else if (pick < 93) queue_event(OP_ON, rand_temp(), 1'($urandom_range(1)));
      else if (pick < 96) queue_event(OP_RESERVED, rand_temp(), 1'($urandom_range(1)));
      else queue_event(OP_OFF, rand_temp(), 1'($urandom_range(1)));
    end
    if ($urandom_range(1)) queue_event(OP_OFF, rand_temp(), 1'($urandom_range(1)));
  endtask

  task automatic queue_random(int n);
    int start;
    start = items_queued;
    while (items_queued - start < n) begin
      if ($urandom_range(9) < 8) queue_session();
      else queue_event(2'($urandom_range(3)), rand_temp(), 1'($urandom_range(1)));
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_TARGET:     cfg_m.target     = value[TEMP_W-1:0];
      REG_GAIN_P:     cfg_m.kp         = value[GAIN_W-1:0];
      REG_GAIN_I:     cfg_m.ki         = value[GAIN_W-1:0];
      REG_GAIN_D:     cfg_m.kd         = value[GAIN_W-1:0];
      REG_OVERHEAT:   cfg_m.overheat   = value[TEMP_W-1:0];
      REG_AMBIENT:    cfg_m.ambient    = value[TEMP_W-1:0];
      REG_AMBIENT_TO: cfg_m.ambient_to = value[TICK_W-1:0];
      default:        cfg_m.regul_to   = value[TICK_W-1:0];
    endcase
  endtask

  task automatic apply_profile(cfg_profile_e prof);
    int v[8];
    case (prof)
      CFG_SHORT_TIMEOUTS: begin
        v[REG_TARGET]     = $urandom_range(2000, 1200);
        v[REG_GAIN_P]     = $urandom_range(1024, 128);
        v[REG_GAIN_I]     = $urandom_range(64);
        v[REG_GAIN_D]     = $urandom_range(512);
        v[REG_OVERHEAT]   = v[REG_TARGET] + 800;
        v[REG_AMBIENT]    = v[REG_TARGET] - int'($urandom_range(400));
        v[REG_AMBIENT_TO] = $urandom_range(9);
        v[REG_REGUL_TO]   = $urandom_range(11);
      end
      CFG_ALL_HIGH: begin
        v = '{32767, 65535, 65535, 65535, 32767, 32767, 65535, 65535};
      end
      CFG_ALL_LOW: begin
        v = '{-32768, 0, 0, 0, -32768, -32768, 0, 0};
      end
      CFG_FULL_RANDOM: begin
        foreach (v[i]) v[i] = $urandom_range(65535);
      end
      default: begin
        v[REG_TARGET]     = int'($urandom_range(4000)) - 800;
        v[REG_GAIN_P]     = $urandom_range(4096);
        v[REG_GAIN_I]     = $urandom_range(256);
        v[REG_GAIN_D]     = $urandom_range(2048);
        v[REG_OVERHEAT]   = v[REG_TARGET] + int'($urandom_range(1600, 32));
        v[REG_AMBIENT]    = v[REG_TARGET] - int'($urandom_range(1600));
        v[REG_AMBIENT_TO] = $urandom_range(12);
        v[REG_REGUL_TO]   = $urandom_range(12);
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_e'(i), v[i]);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idle(idle_profile_e idle);
    send_idle_pct = (idle == IDLE_SENDER) ? 88 : (idle == IDLE_BOTH) ? 31 : 0;
    stall_pct     = (idle == IDLE_RECEIVER) ? 88 : (idle == IDLE_BOTH) ? 31 : 0;
  endtask

  task automatic wait_drained();
    wait (results_checked == items_queued);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    #(RUN_LIMIT);
    $display("FAIL heater_supervisor_with_pid_top");
    $finish;
  end

  initial begin
    cfg_profile_e  prof;
    idle_profile_e idle;
    int            n;

    cfg_m.target     = 16'sd1600;
    cfg_m.kp         = 16'd256;
    cfg_m.ki         = '0;
    cfg_m.kd         = '0;
    cfg_m.overheat   = 16'sd4800;
    cfg_m.ambient    = 16'sd640;
    cfg_m.ambient_to = 16'd300;
    cfg_m.regul_to   = 16'd3000;
    mode_m       = MODE_OFF;
    fault_m      = FAULT_NONE;
    integ_m      = '0;
    prev_err_m   = '0;
    duty_m       = '0;
    heat_ticks_m = '0;
    settle_m     = '0;
    led_m        = 1'b0;

    rst_ni                   = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_idx_i                = REG_TARGET;
    cfg_data_i               = '0;
    ev_ch.valid              = 1'b0;
    ev_ch.op                 = OP_TICK;
    ev_ch.sample_temperature = '0;
    ev_ch.sample_valid       = 1'b0;
    st_ch.ready              = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass on reset settings through the off, heating, regulated and shutdown modes
    set_idle(IDLE_NONE);
    queue_event(OP_TICK, 1600, 1'b1);       // tick while off
    queue_event(OP_RESERVED, 0, 1'b0);
    queue_event(OP_ON, 0, 1'b0);
    queue_event(OP_ON, 0, 1'b0);            // already heating
    queue_event(OP_TICK, 32767, 1'b0);      // sensor not valid
    queue_event(OP_TICK, -32768, 1'b1);     // full-scale error, duty pinned high
    queue_event(OP_TICK, 4800, 1'b1);       // right at the overheat limit
    queue_event(OP_TICK, 4801, 1'b1);       // overheat
    queue_event(OP_TICK, 1600, 1'b1);       // tick while shut down
    queue_event(OP_ON, 0, 1'b0);            // restart clears the fault
    queue_event(OP_OFF, 0, 1'b0);
    queue_event(OP_ON, 0, 1'b0);
    for (int i = 0; i < SETTLE_TICKS; i++) queue_event(OP_TICK, 1580 + 5 * i, 1'b1);
    queue_event(OP_ON, 0, 1'b0);            // already regulated
    queue_event(OP_TICK, 32767, 1'b1);
    queue_event(OP_OFF, 0, 1'b0);           // off from shutdown
    wait_drained();

    for (int ph = 1; ph <= 8; ph++) begin
      case (ph)
        1:       begin prof = CFG_SHORT_TIMEOUTS; idle = IDLE_NONE;     n = 150; end
        2:       begin prof = CFG_ALL_HIGH;       idle = IDLE_SENDER;   n = 120; end
        3:       begin prof = CFG_NEAR_TARGET;    idle = IDLE_RECEIVER; n = 180; end
        4:       begin prof = CFG_FULL_RANDOM;    idle = IDLE_BOTH;     n = 120; end
        5:       begin prof = CFG_ALL_LOW;        idle = IDLE_NONE;     n = 100; end
        6:       begin prof = CFG_NEAR_TARGET;    idle = IDLE_BOTH;     n = 180; end
        7:       begin prof = CFG_SHORT_TIMEOUTS; idle = IDLE_SENDER;   n = 150; end
        default: begin prof = CFG_NEAR_TARGET;    idle = IDLE_RECEIVER; n = 120; end
      endcase
      apply_profile(prof);
      set_idle(idle);
      if (ph == 1) hold_go = 1'b1;
      queue_random(n);
      wait_drained();
    end

    if (mismatches == 0 && status_q.size() == 0) begin
      $display("PASS heater_supervisor_with_pid_top");
    end else begin
      $display("FAIL heater_supervisor_with_pid_top");
    end
    $finish;
  end

endmodule

/* heater_supervisor_with_pid_top.f */
sv/hsup_pkg.sv
sv/hsup_if.sv
sv/hsup_cfg.sv
sv/hsup_pid.sv
sv/hsup_ctrl.sv
sv/heater_supervisor_with_pid_top.sv
dv/tb_heater_supervisor_with_pid_top.sv
